// ===== hdl/bke_pkg.sv =====
// Package for the blink keyframe envelope block: payload structs, timing constants,
// the Q16 keyframe tables and the xorshift32 step. No dependencies.
package bke_pkg;

    localparam int NKEY = 9;
    localparam logic [13:0] GAP_MIN = 14'd3000;
    localparam logic [12:0] GAP_SPAN = 13'd7001;
    // Residue of 2^16 modulo the gap span, used to fold the random word.
    localparam logic [11:0] GAP_FOLD = 12'd2527;
    localparam logic [8:0] BLINK_END = 9'd340;
    localparam logic [20:0] SPEED_FLOOR = 21'd1024;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [20:0] SPEED_RESET = 21'd65536;
    localparam logic [20:0] INTERVAL_RESET = 21'd65536;
    localparam logic [31:0] SEED_RESET = 32'd2463534242;

    localparam logic [1:0] CFG_SPEED = 2'd0;
    localparam logic [1:0] CFG_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_SEED = 2'd2;

    localparam logic [8:0] KEY_T [NKEY] = '{
        9'd0, 9'd35, 9'd70, 9'd105, 9'd140, 9'd175, 9'd215, 9'd265, 9'd340
    };
    localparam logic [16:0] KEY_H [NKEY] = '{
        17'd65536, 17'd55706, 17'd36045, 17'd6554, 17'd2621,
        17'd9830, 17'd36045, 17'd55706, 17'd65536
    };
    localparam logic [16:0] KEY_W [NKEY] = '{
        17'd65536, 17'd67502, 17'd72090, 17'd79954, 17'd86508,
        17'd79954, 17'd73400, 17'd67502, 17'd65536
    };

    typedef struct packed {
        logic        mode;
        logic [31:0] now_ms;
    } bke_in_t;

    typedef struct packed {
        logic [16:0] height_scale;
        logic [16:0] width_scale;
        logic        in_blink;
    } bke_out_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x_in);
        logic [31:0] x;
        x = x_in;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

// ===== hdl/blink_keyframe_envelope_core.sv =====
// Top level of the blink keyframe envelope: sequencer around one restoring divider
// and one multiplier. Depends on bke_pkg.
//
// One item is taken at a time; in_ready is high only while the sequencer is idle,
// and the result goes to an output register so the next item can be taken while it
// waits. The first item after reset also draws the first random gap. The shared
// divider yields one quotient bit per cycle: 48 steps for the elapsed table time and
// 23 for the segment fraction. The random gap modulo folds the word five times
// through the multiplier and finishes with four compare and subtract steps. The two
// scale interpolations and the gap scaling share the same registered multiplier.
module blink_keyframe_envelope_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bke_pkg::bke_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output bke_pkg::bke_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import bke_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ARM, S_CHECK, S_DIV, S_DISPATCH, S_SEG,
        S_MUL_H, S_MUL_W, S_W_DONE, S_GAP_MUL, S_GAP_END, S_OUT,
        S_FOLD, S_REDUCE
    } state_t;

    typedef enum logic [1:0] {
        P_FIRST, P_EL, P_T, P_GAP
    } purpose_t;

    state_t      state_reg;
    purpose_t    purpose_reg;

    logic [20:0] speed_reg;
    logic [20:0] interval_reg;
    logic [31:0] seed_reg;

    logic        blinking_reg;
    logic [31:0] start_reg;
    logic [31:0] next_blink_reg;
    logic [31:0] rng_reg;
    logic        armed_reg;

    logic        mode_reg;
    logic [31:0] now_reg;

    logic [47:0] dvd_reg;
    logic [20:0] dsr_reg;
    logic [20:0] rem_reg;
    logic [47:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] mod_reg;

    logic [2:0]  lo_reg;
    logic [15:0] t_reg;
    logic [13:0] gap_reg;
    logic signed [43:0] prod_reg;
    logic [16:0] h_reg;
    logic [16:0] w_reg;
    logic        inb_reg;

    bke_out_t    out_reg;
    logic        out_valid_reg;

    logic [21:0] trial;
    logic [21:0] trial_diff;
    logic        trial_ge;
    logic [20:0] rem_next;

    logic [31:0] x_first;
    logic [31:0] x_gap;
    logic [31:0] dnext;
    logic        start_blink;
    logic [31:0] el_diff;
    logic [20:0] speed_eff;
    logic [15:0] red_sub;
    logic        red_ge;

    logic [8:0]  e_val;
    logic [2:0]  lo_next;
    logic [3:0]  lo_idx;
    logic [3:0]  hi_idx;
    logic [8:0]  seg_off;
    logic [8:0]  seg_len;

    logic signed [17:0] dh;
    logic signed [17:0] dw;
    logic signed [21:0] mul_a;
    logic signed [21:0] mul_b;
    logic signed [43:0] prod_next;
    logic [17:0] h_sum;
    logic [17:0] w_sum;
    logic [13:0] gap_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[47]};
        trial_diff = trial - {1'b0, dsr_reg};
        trial_ge = (trial >= {1'b0, dsr_reg});
        rem_next = trial_ge ? trial_diff[20:0] : trial[20:0];
    end

    always_comb
    begin
        x_first = xorshift32(seed_reg);
        x_gap = xorshift32(rng_reg);
        dnext = now_reg - next_blink_reg;
        start_blink = !blinking_reg && (mode_reg || !dnext[31]);
        el_diff = start_blink ? 32'd0 : (now_reg - start_reg);
        speed_eff = (speed_reg > SPEED_FLOOR) ? speed_reg : SPEED_FLOOR;
        red_sub = {3'd0, GAP_SPAN} << cnt_reg[1:0];
        red_ge = (mod_reg[15:0] >= red_sub);
        gap_next = GAP_MIN + {1'b0, mod_reg[12:0]};
    end

    always_comb
    begin
        e_val = quo_reg[8:0];
        lo_next = 3'd0;
        for (int k = 1; k < NKEY - 1; k++)
        begin
            if (KEY_T[k] <= e_val)
            begin
                lo_next = lo_next + 3'd1;
            end
        end
        lo_idx = {1'b0, lo_reg};
        hi_idx = lo_idx + 4'd1;
        seg_off = e_val - KEY_T[{1'b0, lo_next}];
        seg_len = KEY_T[{1'b0, lo_next} + 4'd1] - KEY_T[{1'b0, lo_next}];
    end

    always_comb
    begin
        dh = $signed({1'b0, KEY_H[hi_idx]}) - $signed({1'b0, KEY_H[lo_idx]});
        dw = $signed({1'b0, KEY_W[hi_idx]}) - $signed({1'b0, KEY_W[lo_idx]});
        case (state_reg)
            S_MUL_H:
            begin
                mul_a = 22'(dh);
                mul_b = $signed({6'd0, t_reg});
            end
            S_MUL_W:
            begin
                mul_a = 22'(dw);
                mul_b = $signed({6'd0, t_reg});
            end
            S_FOLD:
            begin
                mul_a = $signed({6'd0, mod_reg[31:16]});
                mul_b = $signed({10'd0, GAP_FOLD});
            end
            default:
            begin
                mul_a = $signed({8'd0, gap_reg});
                mul_b = $signed({1'b0, interval_reg});
            end
        endcase
        prod_next = mul_a * mul_b;
        h_sum = {1'b0, KEY_H[lo_idx]} + prod_reg[33:16];
        w_sum = {1'b0, KEY_W[lo_idx]} + prod_reg[33:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            purpose_reg <= P_FIRST;
            speed_reg <= SPEED_RESET;
            interval_reg <= INTERVAL_RESET;
            seed_reg <= SEED_RESET;
            blinking_reg <= 1'b0;
            start_reg <= '0;
            next_blink_reg <= '0;
            rng_reg <= '0;
            armed_reg <= 1'b0;
            mode_reg <= 1'b0;
            now_reg <= '0;
            dvd_reg <= '0;
            dsr_reg <= '0;
            rem_reg <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
            mod_reg <= '0;
            lo_reg <= '0;
            t_reg <= '0;
            gap_reg <= '0;
            prod_reg <= '0;
            h_reg <= ONE_Q16;
            w_reg <= ONE_Q16;
            inb_reg <= 1'b0;
            out_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SPEED: speed_reg <= cfg_data[20:0];
                    CFG_INTERVAL: interval_reg <= cfg_data[20:0];
                    CFG_SEED: seed_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg <= in_data.mode;
                        now_reg <= in_data.now_ms;
                        state_reg <= S_ARM;
                    end
                end
                S_ARM:
                begin
                    if (!armed_reg)
                    begin
                        rng_reg <= x_first;
                        mod_reg <= x_first;
                        cnt_reg <= 6'd5;
                        purpose_reg <= P_FIRST;
                        state_reg <= S_FOLD;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (blinking_reg || start_blink)
                    begin
                        blinking_reg <= 1'b1;
                        if (start_blink)
                        begin
                            start_reg <= now_reg;
                        end
                        dvd_reg <= {el_diff, 16'd0};
                        dsr_reg <= speed_eff;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= 6'd48;
                        purpose_reg <= P_EL;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        h_reg <= ONE_Q16;
                        w_reg <= ONE_Q16;
                        inb_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[46:0], trial_ge};
                    dvd_reg <= {dvd_reg[46:0], 1'b0};
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd1)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                end
                S_FOLD:
                begin
                    mod_reg <= prod_next[31:0] + {16'd0, mod_reg[15:0]};
                    if (cnt_reg == 6'd1)
                    begin
                        cnt_reg <= 6'd3;
                        state_reg <= S_REDUCE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_REDUCE:
                begin
                    if (red_ge)
                    begin
                        mod_reg <= {16'd0, mod_reg[15:0] - red_sub};
                    end
                    if (cnt_reg == 6'd0)
                    begin
                        state_reg <= S_DISPATCH;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                S_DISPATCH:
                begin
                    case (purpose_reg)
                        P_FIRST:
                        begin
                            next_blink_reg <= now_reg + {18'd0, gap_next};
                            armed_reg <= 1'b1;
                            state_reg <= S_CHECK;
                        end
                        P_EL:
                        begin
                            if (quo_reg >= {39'd0, BLINK_END})
                            begin
                                blinking_reg <= 1'b0;
                                rng_reg <= x_gap;
                                mod_reg <= x_gap;
                                cnt_reg <= 6'd5;
                                purpose_reg <= P_GAP;
                                state_reg <= S_FOLD;
                            end
                            else
                            begin
                                state_reg <= S_SEG;
                            end
                        end
                        P_T:
                        begin
                            t_reg <= quo_reg[15:0];
                            state_reg <= S_MUL_H;
                        end
                        default:
                        begin
                            gap_reg <= gap_next;
                            state_reg <= S_GAP_MUL;
                        end
                    endcase
                end
                S_SEG:
                begin
                    lo_reg <= lo_next;
                    dvd_reg <= {seg_off[6:0], 16'd0, 25'd0};
                    dsr_reg <= {12'd0, seg_len};
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= 6'd23;
                    purpose_reg <= P_T;
                    state_reg <= S_DIV;
                end
                S_MUL_H:
                begin
                    prod_reg <= prod_next;
                    state_reg <= S_MUL_W;
                end
                S_MUL_W:
                begin
                    h_reg <= h_sum[16:0];
                    prod_reg <= prod_next;
                    state_reg <= S_W_DONE;
                end
                S_W_DONE:
                begin
                    w_reg <= w_sum[16:0];
                    inb_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_GAP_MUL:
                begin
                    prod_reg <= prod_next;
                    state_reg <= S_GAP_END;
                end
                S_GAP_END:
                begin
                    next_blink_reg <= now_reg + {13'd0, prod_reg[34:16]};
                    h_reg <= ONE_Q16;
                    w_reg <= ONE_Q16;
                    inb_reg <= 1'b0;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_reg.height_scale <= h_reg;
                        out_reg.width_scale <= w_reg;
                        out_reg.in_blink <= inb_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

endmodule

// ===== hdl/bke_checker.sv =====
// Port-level checker for the blink keyframe envelope core, bound to the top level.
// Depends on bke_pkg.
module bke_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input bke_pkg::bke_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input bke_pkg::bke_out_t out_data,
    input logic              cfg_we,
    input logic [1:0]        cfg_index,
    input logic [31:0]       cfg_data
);
    import bke_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready stayed high after an item was taken");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result item changed or dropped");

    a_open_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.in_blink) |->
        (out_data.height_scale == ONE_Q16 && out_data.width_scale == ONE_Q16))
        else $error("scales not at unity outside a blink");

    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.height_scale <= ONE_Q16 &&
                       out_data.width_scale >= ONE_Q16 &&
                       out_data.width_scale <= KEY_W[4]))
        else $error("scale outside the keyframe envelope");

endmodule

bind blink_keyframe_envelope_core bke_checker u_bke_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for blink_keyframe_envelope_core: directed and random tick streams,
// predicted cycle-free in SystemVerilog and compared item by item at the output.
// Depends on bke_pkg and blink_keyframe_envelope_core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bke_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 2000000;
    localparam int unsigned DRAIN_CYCLES = 200;

    localparam int unsigned FRAME_T [9] = '{0, 35, 70, 105, 140, 175, 215, 265, 340};
    localparam int FRAME_H [9] = '{
        65536, 55706, 36045, 6554, 2621, 9830, 36045, 55706, 65536
    };
    localparam int FRAME_W [9] = '{
        65536, 67502, 72090, 79954, 86508, 79954, 73400, 67502, 65536
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    bke_in_t     in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    bke_out_t    out_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SPEED;
    logic [31:0] cfg_data = '0;

    blink_keyframe_envelope_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    logic [20:0] speed_cfg = SPEED_RESET;
    logic [20:0] interval_cfg = INTERVAL_RESET;
    logic [31:0] seed_cfg = SEED_RESET;

    logic        eye_blinking = 1'b0;
    logic [31:0] blink_t0 = '0;
    logic [31:0] next_blink_at = '0;
    logic [31:0] gap_rng = '0;
    logic        schedule_armed = 1'b0;

    bke_out_t    pending_envelopes [$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_request = 0;
    bit          no_idle = 1'b0;
    logic [31:0] clock_ms = '0;

    function automatic logic [31:0] draw_gap();
        logic [31:0] x;
        x = gap_rng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        gap_rng = x;
        return 32'd3000 + (x % 32'd7001);
    endfunction

    function automatic bke_out_t predict_envelope(input bke_in_t item);
        bke_out_t    res;
        logic [31:0] now;
        logic [31:0] diff;
        logic [31:0] sp;
        logic [47:0] el;
        logic [63:0] scaled;
        int unsigned e;
        int          k;
        longint      seg_t;
        longint      hh;
        longint      ww;
        now = item.now_ms;
        res.height_scale = 17'd65536;
        res.width_scale = 17'd65536;
        if (!schedule_armed) begin
            gap_rng = seed_cfg;
            next_blink_at = now + draw_gap();
            schedule_armed = 1'b1;
        end
        if (item.mode && !eye_blinking) begin
            eye_blinking = 1'b1;
            blink_t0 = now;
        end
        if (!eye_blinking) begin
            diff = now - next_blink_at;
            if (!diff[31]) begin
                eye_blinking = 1'b1;
                blink_t0 = now;
            end
        end
        if (eye_blinking) begin
            sp = (speed_cfg > 21'd1024) ? 32'(speed_cfg) : 32'd1024;
            diff = now - blink_t0;
            el = {diff, 16'h0000} / 48'(sp);
            if (el >= 48'd340) begin
                eye_blinking = 1'b0;
                scaled = 64'(draw_gap()) * 64'(interval_cfg);
                next_blink_at = now + scaled[47:16];
            end else begin
                e = el[31:0];
                k = 1;
                while (k < 8 && FRAME_T[k] <= e)
                    k++;
                seg_t = longint'(((e - FRAME_T[k-1]) << 16) / (FRAME_T[k] - FRAME_T[k-1]));
                hh = longint'(FRAME_H[k-1])
                    + ((longint'(FRAME_H[k] - FRAME_H[k-1]) * seg_t) >>> 16);
                ww = longint'(FRAME_W[k-1])
                    + ((longint'(FRAME_W[k] - FRAME_W[k-1]) * seg_t) >>> 16);
                res.height_scale = hh[16:0];
                res.width_scale = ww[16:0];
            end
        end
        res.in_blink = eye_blinking;
        return res;
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 16);
        return $urandom_range(40, 250);
    endfunction

    task automatic report_mismatch(input string what, input bke_out_t want, input bke_out_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected h=%0d w=%0d blink=%0d, got h=%0d w=%0d blink=%0d",
                     what, want.height_scale, want.width_scale, want.in_blink,
                     got.height_scale, got.width_scale, got.in_blink);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        in_valid <= 1'b0;
        while (pending_envelopes.size() != 0)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_SPEED:    speed_cfg = value[20:0];
            CFG_INTERVAL: interval_cfg = value[20:0];
            CFG_SEED:     seed_cfg = value;
            default:      ;
        endcase
    endtask

    task automatic send_item(input logic mode, input logic [31:0] now);
        bke_in_t     item;
        int unsigned gap;
        cfg_we <= 1'b0;
        gap = no_idle ? 0 : pick_idle();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.mode = mode;
        item.now_ms = now;
        in_valid <= 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (!in_ready);
        pending_envelopes.push_back(predict_envelope(item));
    endtask

    task automatic test_first_tick();
        write_register(CFG_SEED, $urandom | 32'h0000_0001);
        send_item(1'b0, 32'hFFFF_FE00);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h0000_0000);
        send_item(1'b0, 32'd1000);
    endtask

    task automatic test_blink_request();
        clock_ms = 32'd1500;
        send_item(1'b1, clock_ms);
        for (int i = 0; i < 14; i++) begin
            clock_ms += 32'd25;
            send_item(i == 5, clock_ms);
        end
    endtask

    task automatic test_long_blink();
        clock_ms += 32'd10;
        send_item(1'b1, clock_ms);
        clock_ms += 32'h9000_0000;
        send_item(1'b0, clock_ms);
    endtask

    task automatic test_speed_floor();
        write_register(CFG_SPEED, 32'd0);
        write_register(CFG_INTERVAL, 32'd0);
        clock_ms += 32'd1;
        send_item(1'b1, clock_ms);
        clock_ms += 32'd3;
        send_item(1'b0, clock_ms);
        clock_ms += 32'd3;
        send_item(1'b0, clock_ms);
        clock_ms += 32'd1;
        send_item(1'b0, clock_ms);
    endtask

    task automatic test_random_frames(input logic [31:0] speed, input logic [31:0] interval,
                                      input logic [31:0] seed, input int unsigned step_max,
                                      input bit calm, input int unsigned count);
        int unsigned r;
        write_register(CFG_SPEED, speed);
        write_register(CFG_INTERVAL, interval);
        write_register(CFG_SEED, seed);
        no_idle = calm;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                clock_ms = $urandom;
            else if (r < 5)
                clock_ms += $urandom;
            else
                clock_ms += $urandom_range(0, step_max);
            send_item($urandom_range(0, 99) < 6, clock_ms);
        end
        no_idle = 1'b0;
    endtask

    task automatic test_output_backpressure();
        no_idle = 1'b1;
        hold_request = 500;
        repeat (12) begin
            clock_ms += 32'd7;
            send_item($urandom_range(0, 3) == 0, clock_ms);
        end
        no_idle = 1'b0;
    endtask

    initial begin : receiver
        int unsigned hold;
        int unsigned stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                hold = hold_request;
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            if (stall != 0) begin
                stall--;
                out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                stall = pick_idle();
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        bke_out_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_envelopes.size() == 0) begin
                report_mismatch("unexpected item", '0, out_data);
            end else begin
                want = pending_envelopes.pop_front();
                if (out_data.height_scale !== want.height_scale
                    || out_data.width_scale !== want.width_scale
                    || out_data.in_blink !== want.in_blink)
                    report_mismatch("mismatch", want, out_data);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("blink_keyframe_envelope_core verification failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_tick();
        test_blink_request();
        test_long_blink();
        test_speed_floor();

        test_random_frames(32'd65536, 32'd65536, 32'd0, 40, 1'b0, 150);
        test_random_frames(32'd0, 32'd0, 32'hFFFF_FFFF, 8, 1'b0, 150);
        test_random_frames(32'd1048576, 32'd1048576, 32'd1, 400, 1'b0, 130);
        test_output_backpressure();
        test_random_frames($urandom_range(0, 1048576), $urandom_range(0, 1048576),
                           $urandom, 60, 1'b1, 130);
        test_random_frames(32'd1024, 32'd1048576, $urandom, 10, 1'b0, 140);
        test_random_frames($urandom_range(0, 1048576), $urandom_range(0, 1048576),
                           $urandom, 100, 1'b0, 140);

        in_valid <= 1'b0;
        while (pending_envelopes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_envelopes.size() == 0)
            $display("blink_keyframe_envelope_core verification clean");
        else
            $display("blink_keyframe_envelope_core verification failed");
        $finish;
    end
endmodule

// ===== blink_keyframe_envelope_core.f =====
hdl/bke_pkg.sv
hdl/blink_keyframe_envelope_core.sv
hdl/bke_checker.sv
tb/testbench.sv
